[sv/pli_pkg.sv]
// Shared widths, function and status codes, and the command and status
// structs that join the controller to the datapath of the list block.
// No dependencies.
package pli_pkg;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 7;
  localparam int KEY_W    = 16;
  localparam int RND_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RAND   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                load;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                ptr_from_count;
    logic                ptr_from_pos;
    logic                ptr_from_rem;
    logic                ptr_dec;
    logic                ptr_inc;
    logic                rd_prev;
    logic                rd_next;
    logic                wr_shift;
    logic                wr_value;
    logic                key_capture;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                div_start;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ins_range;
    logic              full;
    logic              rem_range;
    logic              empty;
    logic              ptr_at_pos;
    logic              rem_last;
    logic              div_done;
  } dp_status_t;

endpackage

[sv/pli_if.sv]
// Request and result channel interfaces of the list block.
// Depends on pli_pkg for the field widths.
interface pli_req_if;
  logic                          valid;
  logic                          ready;
  logic [pli_pkg::FUNC_W-1:0]    func;
  logic [pli_pkg::POS_W-1:0]     position;
  logic [pli_pkg::KEY_W-1:0]     value;
  logic [pli_pkg::RND_W-1:0]     random_word;

  modport source (output valid, func, position, value, random_word, input ready);
  modport sink   (input valid, func, position, value, random_word, output ready);
endinterface

interface pli_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pli_pkg::KEY_W-1:0]     removed_key;
  logic [pli_pkg::STATUS_W-1:0]  status;
  logic [pli_pkg::LEN_W-1:0]     list_length;

  modport source (output valid, removed_key, status, list_length, input ready);
  modport sink   (input valid, removed_key, status, list_length, output ready);
endinterface

[sv/pli_mod.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Standalone; used by pli_dp for the random position.
module pli_mod #(
  parameter int DVD_W  = 16,
  parameter int DIVS_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVS_W-1:0] rem
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DVD_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[DIVS_W-1:0];
      end else begin
        rem <= trial[DIVS_W-1:0];
      end
    end
  end

endmodule

[sv/pli_dp.sv]
// Datapath of the list block: key memory, length, shift pointer, request
// and result registers. Depends on pli_pkg and pli_mod.
module pli_dp #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pli_pkg::cmd_t                 cmd,
  output pli_pkg::dp_status_t           st,
  input  logic [pli_pkg::FUNC_W-1:0]    func,
  input  logic [pli_pkg::POS_W-1:0]     position,
  input  logic [pli_pkg::KEY_W-1:0]     value,
  input  logic [pli_pkg::RND_W-1:0]     random_word,
  output logic [pli_pkg::KEY_W-1:0]     removed_key,
  output logic [pli_pkg::STATUS_W-1:0]  status,
  output logic [pli_pkg::LEN_W-1:0]     list_length
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = pli_pkg::POS_W;
  localparam int LEN_W  = pli_pkg::LEN_W;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [pli_pkg::FUNC_W-1:0]   func_r;
  logic [POS_W-1:0]             pos_r;
  logic [pli_pkg::KEY_W-1:0]    value_r;
  logic [pli_pkg::RND_W-1:0]    rnd_r;
  logic [pli_pkg::KEY_W-1:0]    removed;
  logic [pli_pkg::STATUS_W-1:0] stat;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             ptr;
  logic [CNT_W-1:0]             rd_ptr;
  logic [CNT_W-1:0]             div_rem;
  logic [pli_pkg::KEY_W-1:0]    mem [DEPTH];
  logic [pli_pkg::KEY_W-1:0]    rdata;
  logic [CMP_W-1:0]             pos_x;
  logic [CMP_W-1:0]             cnt_x;
  logic [CMP_W-1:0]             ptr_x;
  logic                         div_done;

  assign pos_x = CMP_W'(pos_r);
  assign cnt_x = CMP_W'(count);
  assign ptr_x = CMP_W'(ptr);

  always_comb begin
    st.func       = func_r;
    st.ins_range  = pos_x > cnt_x;
    st.full       = count >= CNT_W'(DEPTH);
    st.rem_range  = pos_x >= cnt_x;
    st.empty      = count == '0;
    st.ptr_at_pos = ptr_x == pos_x;
    st.rem_last   = (ptr_x + CMP_W'(1)) >= cnt_x;
    st.div_done   = div_done;
  end

  always_comb begin
    if (cmd.rd_prev) begin
      rd_ptr = ptr - CNT_W'(1);
    end else if (cmd.rd_next) begin
      rd_ptr = ptr + CNT_W'(1);
    end else begin
      rd_ptr = ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem[ptr[ADDR_W-1:0]] <= rdata;
    end else if (cmd.wr_value) begin
      mem[ptr[ADDR_W-1:0]] <= value_r;
    end
    rdata <= mem[rd_ptr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      pos_r   <= position;
      value_r <= value;
      rnd_r   <= random_word;
      removed <= '0;
      stat    <= pli_pkg::ST_OK;
    end else begin
      if (cmd.set_status) begin
        stat <= cmd.status_code;
      end
      if (cmd.key_capture) begin
        removed <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_from_count) begin
      ptr <= count;
    end else if (cmd.ptr_from_pos) begin
      ptr <= CNT_W'(pos_r);
    end else if (cmd.ptr_from_rem) begin
      ptr <= div_rem;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - CNT_W'(1);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      removed_key <= removed;
      status      <= stat;
      list_length <= LEN_W'(count);
    end
  end

  pli_mod #(
    .DVD_W  (pli_pkg::RND_W),
    .DIVS_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rnd_r),
    .divisor  (count),
    .done     (div_done),
    .rem      (div_rem)
  );

endmodule

[sv/pli_ctrl.sv]
// Controller of the list block: sequences checks, remainder and shifts,
// and owns both handshakes. Depends on pli_pkg.
module pli_ctrl (
  input  logic                clk,
  input  logic                rst,
  output pli_pkg::cmd_t       cmd,
  input  pli_pkg::dp_status_t st,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_REM_RD  = 4'd3;
  localparam logic [3:0] S_REM_KEY = 4'd4;
  localparam logic [3:0] S_REM_CHK = 4'd5;
  localparam logic [3:0] S_REM_WR  = 4'd6;
  localparam logic [3:0] S_INS_RD  = 4'd7;
  localparam logic [3:0] S_INS_WR  = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          pli_pkg::FN_INSERT: begin
            if (st.ins_range) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = pli_pkg::ST_RANGE;
              state_next      = S_FIN;
            end else if (st.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = pli_pkg::ST_FULL;
              state_next      = S_FIN;
            end else begin
              cmd.ptr_from_count = 1'b1;
              state_next         = S_INS_RD;
            end
          end
          pli_pkg::FN_REMOVE: begin
            if (st.rem_range) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = pli_pkg::ST_RANGE;
              state_next      = S_FIN;
            end else begin
              cmd.ptr_from_pos = 1'b1;
              state_next       = S_REM_RD;
            end
          end
          pli_pkg::FN_RAND: begin
            if (st.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = pli_pkg::ST_EMPTY;
              state_next      = S_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          pli_pkg::FN_NONE: begin
            state_next = S_FIN;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.ptr_from_rem = 1'b1;
          state_next       = S_REM_RD;
        end
      end
      S_REM_RD: begin
        state_next = S_REM_KEY;
      end
      S_REM_KEY: begin
        cmd.key_capture = 1'b1;
        state_next      = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (st.rem_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_next   = S_REM_CHK;
      end
      S_INS_RD: begin
        if (st.ptr_at_pos) begin
          cmd.wr_value = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec  = 1'b1;
        state_next   = S_INS_RD;
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/positional_list_insert_remove.sv]
// Top level of the positional list: joins pli_ctrl and pli_dp to the
// request and result channels. Depends on pli_pkg, pli_if, pli_ctrl, pli_dp.
//
// Requests arrive on req (func, position, value, random_word) and each
// gives exactly one result on rsp (removed_key, status, list_length).
// One request is worked at a time; req.ready is high only while idle.
// A rejected request or an unused function code goes straight to the
// result. An insert moves the keys from position onward up by one place;
// a remove moves the keys behind position down by one. A random remove
// first takes the bit-serial remainder of random_word by the length and
// then removes at that position. Shifts move one key at a time through
// the key memory, with a read state and then a write state for each key.
// The next request is taken the cycle after a result is registered, even
// if rsp is stalled; a stalled result holds until taken and the following
// result waits behind it. Reset empties the list at once; no clearing
// pass is run over the key memory.
module positional_list_insert_remove #(
  parameter int DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  pli_req_if.sink   req,
  pli_rsp_if.source rsp
);

  pli_pkg::cmd_t       cmd;
  pli_pkg::dp_status_t st;

  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

  pli_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .func        (req.func),
    .position    (req.position),
    .value       (req.value),
    .random_word (req.random_word),
    .removed_key (rsp.removed_key),
    .status      (rsp.status),
    .list_length (rsp.list_length)
  );

`ifndef NO_ASSERTIONS
  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !st.full)
    else $error("insert committed into a full store");

  a_rem_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !st.empty)
    else $error("remove committed from an empty list");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (st.func == pli_pkg::FN_RAND) && !st.empty)
    else $error("remainder started without a random remove on a non-empty list");
`endif

endmodule
